// ===== design/ttl_pkg.sv =====
// package for the text token lexer: state codes, token codes and widths
// no dependencies
package ttl_pkg;

    localparam int MaxMessage = 4096;
    localparam int PosW = $clog2(MaxMessage);

    typedef enum logic [4:0] {
        ST_IDLE, ST_SPACE, ST_ZERO, ST_DEC, ST_PAYLOAD, ST_NAN_A, ST_NAN_N,
        ST_INF_N, ST_INF_F, ST_HX_LEAD, ST_HZ_P, ST_HZ_PLUS, ST_HZ_ZERO,
        ST_HX_DOT, ST_HX_FRAC, ST_HX_ESIGN, ST_HX_EFIRST, ST_HX_EDIG, ST_HX_ESPACE
    } lex_state_t;

    localparam logic [3:0] TOK_END    = 4'd0;
    localparam logic [3:0] TOK_MAP    = 4'd1;
    localparam logic [3:0] TOK_ARRAY  = 4'd2;
    localparam logic [3:0] TOK_INT    = 4'd3;
    localparam logic [3:0] TOK_INT64  = 4'd4;
    localparam logic [3:0] TOK_UINT64 = 4'd5;
    localparam logic [3:0] TOK_DOUBLE = 4'd6;
    localparam logic [3:0] TOK_STRING = 4'd7;
    localparam logic [3:0] TOK_BYTES  = 4'd8;
    localparam logic [3:0] TOK_REF    = 4'd9;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       msg_last;
    } ttl_in_t;

    typedef struct packed {
        logic [3:0]  tok_type;
        logic [63:0] tok_value;
        logic [11:0] payload_offset;
        logic        tok_error;
    } ttl_out_t;

endpackage

// ===== design/ttl_if.sv =====
// valid/ready channel interfaces for the text token lexer
// depends on ttl_pkg
interface ttl_in_if import ttl_pkg::*; ();
    logic    valid;
    logic    ready;
    ttl_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ttl_out_if import ttl_pkg::*; ();
    logic     valid;
    logic     ready;
    ttl_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/text_token_lexer.sv =====
// text token lexer: one message byte per transfer, at most one token out
// a finished token is registered in the output register, or in the one-entry
// skid while the output is held; one byte per cycle while the skid is empty;
// output and skid registers keep input ready while a token waits on the sink
// reset: rst_n async active low clears the lexer state, position and buffers
// depends on ttl_pkg, ttl_if
module text_token_lexer
    import ttl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    ttl_in_if.sink   in_ch,
    ttl_out_if.source out_ch
);

    lex_state_t  state_reg, state_next;
    logic        neg_reg, neg_next;
    logic [63:0] num_reg, num_next;
    logic [63:0] frac_reg, frac_next;
    logic [4:0]  fcnt_reg, fcnt_next;
    logic [31:0] exp_reg, exp_next;
    logic        eneg_reg, eneg_next;
    logic [30:0] rem_reg, rem_next;
    logic [3:0]  pend_reg, pend_next;
    logic [PosW-1:0] pos_reg, pos_next;
    logic        disc_reg, disc_next;

    // output register and skid entry
    logic     ovalid_reg, svalid_reg;
    ttl_out_t odata_reg, sdata_reg;

    logic     emit;
    ttl_out_t tok;
    logic     fire;

    assign in_ch.ready  = !svalid_reg;
    assign fire         = in_ch.valid && in_ch.ready;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = odata_reg;

    logic [7:0] b;
    logic       last;
    logic       dig;
    logic [3:0] dval;
    logic [4:0] hv;      // bit 4 set: not a hex digit
    logic [63:0] num_x10;
    logic [31:0] exp_x10;

    assign b    = in_ch.data.in_byte;
    assign last = in_ch.data.msg_last;
    assign dig  = (b >= "0") && (b <= "9");
    assign dval = b[3:0];
    assign num_x10 = (num_reg << 3) + (num_reg << 1) + {60'd0, dval};
    assign exp_x10 = (exp_reg << 3) + (exp_reg << 1) + {28'd0, dval};

    always_comb
    begin
        if (dig)
            hv = {1'b0, b[3:0]};
        else if (b >= "a" && b <= "f")
            hv = {1'b0, b[3:0] + 4'd9};
        else
            hv = 5'h10;
    end

    // double assembly from the hex-float accumulators
    logic [63:0] dbl_bits;
    logic        dbl_bad;
    always_comb
    begin
        logic [63:0] f;
        logic [10:0] ue;
        f = frac_reg;
        if (fcnt_reg >= 5'd14 && f[11])
            f = f + 64'h800;
        dbl_bad = 1'b0;
        ue = 11'd0;
        if (eneg_reg) begin
            if (exp_reg == 32'd0 || exp_reg > 32'h8000_0000)
                dbl_bad = 1'b1;
            if (exp_reg > 32'd1022) begin
                f = 64'd0;
                ue = 11'd0;
            end else begin
                ue = 11'(11'd1023 - exp_reg[10:0]);
            end
        end else begin
            if (exp_reg > 32'h7FFF_FFFF)
                dbl_bad = 1'b1;
            if (exp_reg > 32'd1023) begin
                f = 64'd0;
                ue = 11'h7FF;
            end else begin
                ue = 11'(11'd1023 + exp_reg[10:0]);
            end
        end
        dbl_bits = {neg_reg, ue, f[63:12]};
    end

    // next-state logic for one byte
    always_comb
    begin
        logic fail;
        logic put;
        logic [12:0] off;
        logic [63:0] sv;
        state_next = state_reg;
        neg_next   = neg_reg;
        num_next   = num_reg;
        frac_next  = frac_reg;
        fcnt_next  = fcnt_reg;
        exp_next   = exp_reg;
        eneg_next  = eneg_reg;
        rem_next   = rem_reg;
        pend_next  = pend_reg;
        pos_next   = pos_reg;
        disc_next  = disc_reg;
        fail = 1'b0;
        put  = 1'b0;
        tok  = '0;
        off  = 13'(pos_reg) + 13'd1;
        sv   = neg_reg ? (64'd0 - num_reg) : num_reg;

        if (!disc_reg) begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (b == 8'h0A || b == 8'h00) begin
                        put = 1'b1;
                        tok.tok_type = TOK_END;
                    end else if (b == "-") begin
                        if (neg_reg) fail = 1'b1;
                        else neg_next = 1'b1;
                    end else if (b == "{") begin
                        pend_next = TOK_MAP; state_next = ST_SPACE;
                    end else if (b == "[") begin
                        pend_next = TOK_ARRAY; state_next = ST_SPACE;
                    end else if (b == "}" || b == "]") begin
                        pend_next = TOK_END; state_next = ST_SPACE;
                    end else if (b == "0") begin
                        num_next = 64'd0; state_next = ST_ZERO;
                    end else if (b == "n") begin
                        pend_next = TOK_DOUBLE;
                        if (neg_reg) fail = 1'b1;
                        else state_next = ST_NAN_A;
                    end else if (b == "i") begin
                        pend_next = TOK_DOUBLE; state_next = ST_INF_N;
                    end else if (dig) begin
                        num_next = {60'd0, dval}; state_next = ST_DEC;
                    end else begin
                        fail = 1'b1;
                    end
                end
                ST_SPACE:
                begin
                    if (b != " ") fail = 1'b1;
                    else begin
                        put = 1'b1;
                        tok.tok_type  = pend_reg;
                        tok.tok_value = num_reg;
                        if (pend_reg == TOK_STRING || pend_reg == TOK_BYTES)
                            tok.payload_offset = frac_reg[11:0];
                    end
                end
                ST_ZERO, ST_DEC:
                begin
                    if (state_reg == ST_ZERO && b == "x") begin
                        pend_next = TOK_DOUBLE; state_next = ST_HX_LEAD;
                    end else if (state_reg == ST_DEC && dig) begin
                        if (num_reg >= 64'h1999_9999_9999_9999) fail = 1'b1;
                        else num_next = num_x10;
                    end else if (b == ":" || b == ";") begin
                        pend_next = (b == ":") ? TOK_STRING : TOK_BYTES;
                        if (neg_reg || num_reg > 64'h7FFF_FFFF) fail = 1'b1;
                        else begin
                            if (off > 13'(MaxMessage - 1))
                                off = 13'(MaxMessage - 1);
                            frac_next = {51'd0, off};
                            if (num_reg == 64'd0)
                                state_next = ST_SPACE;
                            else begin
                                rem_next = num_reg[30:0];
                                state_next = ST_PAYLOAD;
                            end
                        end
                    end else if (b == "@") begin
                        pend_next = TOK_REF;
                        if (neg_reg) fail = 1'b1;
                        else state_next = ST_SPACE;
                    end else if (b == " ") begin
                        if (num_reg < 64'h7FFF_FFFF) begin
                            put = 1'b1; tok.tok_type = TOK_INT; tok.tok_value = sv;
                        end else if (num_reg < 64'h7FFF_FFFF_FFFF_FFFF) begin
                            put = 1'b1; tok.tok_type = TOK_INT64; tok.tok_value = sv;
                        end else begin
                            pend_next = TOK_UINT64;
                            if (neg_reg) fail = 1'b1;
                            else begin
                                put = 1'b1; tok.tok_type = TOK_UINT64;
                                tok.tok_value = num_reg;
                            end
                        end
                    end else begin
                        fail = 1'b1;
                    end
                end
                ST_PAYLOAD:
                begin
                    rem_next = rem_reg - 31'd1;
                    if (rem_reg == 31'd1) state_next = ST_SPACE;
                end
                ST_NAN_A:
                begin
                    if (b != "a") fail = 1'b1; else state_next = ST_NAN_N;
                end
                ST_NAN_N:
                begin
                    if (b != "n") fail = 1'b1;
                    else begin
                        num_next = 64'h7FF8_0000_0000_0000; state_next = ST_SPACE;
                    end
                end
                ST_INF_N:
                begin
                    if (b != "n") fail = 1'b1; else state_next = ST_INF_F;
                end
                ST_INF_F:
                begin
                    if (b != "f") fail = 1'b1;
                    else begin
                        num_next = {neg_reg, 11'h7FF, 52'd0}; state_next = ST_SPACE;
                    end
                end
                ST_HX_LEAD:
                begin
                    if (b == "0") state_next = ST_HZ_P;
                    else if (b == "1") state_next = ST_HX_DOT;
                    else fail = 1'b1;
                end
                ST_HZ_P:
                begin
                    if (b != "p") fail = 1'b1; else state_next = ST_HZ_PLUS;
                end
                ST_HZ_PLUS:
                begin
                    if (b != "+") fail = 1'b1; else state_next = ST_HZ_ZERO;
                end
                ST_HZ_ZERO:
                begin
                    if (b != "0") fail = 1'b1;
                    else begin
                        num_next = {neg_reg, 63'd0}; state_next = ST_SPACE;
                    end
                end
                ST_HX_DOT:
                begin
                    if (b == ".") state_next = ST_HX_FRAC;
                    else if (b == "p") state_next = ST_HX_ESIGN;
                    else fail = 1'b1;
                end
                ST_HX_FRAC:
                begin
                    if (!hv[4] && fcnt_reg < 5'd16) begin
                        frac_next = frac_reg |
                            ({60'd0, hv[3:0]} << (7'd60 - {fcnt_reg, 2'b00}));
                        fcnt_next = fcnt_reg + 5'd1;
                    end else if (b == "p") state_next = ST_HX_ESIGN;
                    else fail = 1'b1;
                end
                ST_HX_ESIGN:
                begin
                    if (b == "+") begin
                        eneg_next = 1'b0; state_next = ST_HX_EFIRST;
                    end else if (b == "-") begin
                        eneg_next = 1'b1; state_next = ST_HX_EFIRST;
                    end else fail = 1'b1;
                end
                ST_HX_EFIRST:
                begin
                    if (b == "0") begin
                        exp_next = 32'd0; state_next = ST_HX_ESPACE;
                    end else if (dig) begin
                        exp_next = {28'd0, dval}; state_next = ST_HX_EDIG;
                    end else fail = 1'b1;
                end
                ST_HX_EDIG, ST_HX_ESPACE:
                begin
                    if (state_reg == ST_HX_EDIG && dig) begin
                        if (exp_reg >= 32'h1999_9999) fail = 1'b1;
                        else exp_next = exp_x10;
                    end else if (b == " ") begin
                        if (dbl_bad) fail = 1'b1;
                        else begin
                            put = 1'b1; tok.tok_type = TOK_DOUBLE;
                            tok.tok_value = dbl_bits;
                        end
                    end else fail = 1'b1;
                end
                default:
                begin
                    state_next = ST_IDLE;
                    neg_next = 1'b0; num_next = '0; frac_next = '0; fcnt_next = '0;
                    exp_next = '0; eneg_next = 1'b0; rem_next = '0; pend_next = '0;
                end
            endcase

            if (fail) begin
                put = 1'b1;
                tok = '0;
                tok.tok_type  = pend_next;
                tok.tok_error = 1'b1;
                disc_next = 1'b1;
            end
            if (put) begin
                state_next = ST_IDLE;
                neg_next = 1'b0; num_next = '0; frac_next = '0; fcnt_next = '0;
                exp_next = '0; eneg_next = 1'b0; rem_next = '0; pend_next = '0;
            end
        end

        emit = put;
        if (last) begin
            // truncated item on the final byte
            if (!disc_reg && !put && (state_next != ST_IDLE || neg_next)) begin
                emit = 1'b1;
                tok = '0;
                tok.tok_type  = pend_next;
                tok.tok_error = 1'b1;
            end
            state_next = ST_IDLE;
            neg_next = 1'b0; num_next = '0; frac_next = '0; fcnt_next = '0;
            exp_next = '0; eneg_next = 1'b0; rem_next = '0; pend_next = '0;
            disc_next = 1'b0;
            pos_next  = '0;
        end else if (pos_reg != PosW'(MaxMessage - 1)) begin
            pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            neg_reg   <= 1'b0;
            num_reg   <= '0;
            frac_reg  <= '0;
            fcnt_reg  <= '0;
            exp_reg   <= '0;
            eneg_reg  <= 1'b0;
            rem_reg   <= '0;
            pend_reg  <= '0;
            pos_reg   <= '0;
            disc_reg  <= 1'b0;
        end else if (fire) begin
            state_reg <= state_next;
            neg_reg   <= neg_next;
            num_reg   <= num_next;
            frac_reg  <= frac_next;
            fcnt_reg  <= fcnt_next;
            exp_reg   <= exp_next;
            eneg_reg  <= eneg_next;
            rem_reg   <= rem_next;
            pend_reg  <= pend_next;
            pos_reg   <= pos_next;
            disc_reg  <= disc_next;
        end
    end

    // output register with skid entry: new tokens go to the output when it
    // frees up, otherwise park in the skid entry which drops input ready
    logic new_tok;
    logic out_free;
    assign new_tok  = fire && emit;
    assign out_free = !ovalid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ovalid_reg <= 1'b0;
            svalid_reg <= 1'b0;
        end else begin
            if (out_free) begin
                if (svalid_reg) begin
                    ovalid_reg <= 1'b1;
                    svalid_reg <= 1'b0;
                end else begin
                    ovalid_reg <= new_tok;
                end
            end else if (new_tok) begin
                svalid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free) begin
            if (svalid_reg)
                odata_reg <= sdata_reg;
            else if (new_tok)
                odata_reg <= tok;
        end else if (new_tok) begin
            sdata_reg <= tok;
        end
    end

endmodule

// ===== verif/tb_text_token_lexer.sv =====
`timescale 1ns / 100ps
// testbench for text_token_lexer: byte messages in, tokens out, checked against a predictor
// depends on ttl_pkg, ttl_if and the text_token_lexer rtl
module tb_text_token_lexer;
    import ttl_pkg::*;

    // expected tokens, worked out byte by byte from an independent copy of the lexer
    class lexer_scoreboard;
        ttl_out_t    expected_tokens[$];
        int          mismatches;
        lex_state_t  st;
        bit          neg;
        logic [63:0] num;
        logic [63:0] frac;
        int          fcnt;
        logic [31:0] expo;
        bit          eneg;
        logic [31:0] prem;
        logic [3:0]  ptype;
        int          pos;
        bit          disc;

        function void clear_tok();
            st = ST_IDLE;
            neg = 0;
            num = '0;
            frac = '0;
            fcnt = 0;
            expo = '0;
            eneg = 0;
            prem = '0;
            ptype = TOK_END;
        endfunction

        function void reset_state();
            clear_tok();
            pos = 0;
            disc = 0;
            mismatches = 0;
        endfunction

        function bit emit(logic [3:0] t, logic [63:0] v, logic [11:0] o, bit e);
            ttl_out_t r;
            r.tok_type = t;
            r.tok_value = v;
            r.payload_offset = o;
            r.tok_error = e;
            expected_tokens.push_back(r);
            clear_tok();
            return 1;
        endfunction

        function bit fail_tok();
            bit r;
            r = emit(ptype, '0, '0, 1);
            disc = 1;
            return 1;
        endfunction

        function int hex_digit(logic [7:0] b);
            if (b >= "0" && b <= "9") return b - "0";
            if (b >= "a" && b <= "f") return b - "a" + 10;
            return -1;
        endfunction

        // delimiter after a decimal number decides its class
        function bit end_number(logic [7:0] b);
            int          off;
            logic [63:0] sv;
            if (b == ":" || b == ";") begin
                off = pos + 1;
                ptype = (b == ":") ? TOK_STRING : TOK_BYTES;
                if (neg || num > 64'h7FFF_FFFF) return fail_tok();
                if (off > MaxMessage - 1) off = MaxMessage - 1;
                frac = 64'(off);
                if (num == 0) st = ST_SPACE;
                else begin
                    prem = num[31:0];
                    st = ST_PAYLOAD;
                end
                return 0;
            end
            if (b == "@") begin
                ptype = TOK_REF;
                if (neg) return fail_tok();
                st = ST_SPACE;
                return 0;
            end
            if (b == " ") begin
                sv = neg ? -num : num;
                if (num < 64'd2147483647) return emit(TOK_INT, sv, '0, 0);
                if (num < 64'h7FFF_FFFF_FFFF_FFFF) return emit(TOK_INT64, sv, '0, 0);
                ptype = TOK_UINT64;
                if (neg) return fail_tok();
                return emit(TOK_UINT64, num, '0, 0);
            end
            return fail_tok();
        endfunction

        // hex float assembly: rounding at bit 53, flush and overflow
        function bit finish_double();
            longint      e;
            logic [63:0] f;
            logic [10:0] uexp;
            f = frac;
            if (eneg) begin
                if (expo == 0 || {32'd0, expo} > 64'h8000_0000) return fail_tok();
                e = -longint'({32'd0, expo});
            end else begin
                if (expo > 32'h7FFF_FFFF) return fail_tok();
                e = longint'({32'd0, expo});
            end
            if (fcnt * 4 > 52 && f[11]) f = f + 64'd2048;
            if (e < -1022) begin
                f = '0;
                uexp = '0;
            end else if (e > 1023) begin
                f = '0;
                uexp = 11'h7FF;
            end else uexp = 11'(1023 + e);
            return emit(TOK_DOUBLE, {neg, uexp, f[63:12]}, '0, 0);
        endfunction

        function bit lex_byte(logic [7:0] b);
            bit dig;
            int hv;
            dig = (b >= "0" && b <= "9");
            case (st)
                ST_IDLE: begin
                    if (b == 8'h0A || b == 8'h00) return emit(TOK_END, '0, '0, 0);
                    if (b == "-") begin
                        if (neg) return fail_tok();
                        neg = 1;
                        return 0;
                    end
                    if (b == "{") begin ptype = TOK_MAP; st = ST_SPACE; return 0; end
                    if (b == "[") begin ptype = TOK_ARRAY; st = ST_SPACE; return 0; end
                    if (b == "}" || b == "]") begin ptype = TOK_END; st = ST_SPACE; return 0; end
                    if (b == "0") begin num = '0; st = ST_ZERO; return 0; end
                    if (b == "n") begin
                        ptype = TOK_DOUBLE;
                        if (neg) return fail_tok();
                        st = ST_NAN_A;
                        return 0;
                    end
                    if (b == "i") begin ptype = TOK_DOUBLE; st = ST_INF_N; return 0; end
                    if (dig) begin num = 64'(b - "0"); st = ST_DEC; return 0; end
                    return fail_tok();
                end
                ST_SPACE: begin
                    if (b != " ") return fail_tok();
                    return emit(ptype, num,
                        (ptype == TOK_STRING || ptype == TOK_BYTES) ? frac[11:0] : 12'd0, 0);
                end
                ST_ZERO: begin
                    if (b == "x") begin ptype = TOK_DOUBLE; st = ST_HX_LEAD; return 0; end
                    return end_number(b);
                end
                ST_DEC: begin
                    if (dig) begin
                        if (num >= 64'd1844674407370955161) return fail_tok();
                        num = num * 10 + (b - "0");
                        return 0;
                    end
                    return end_number(b);
                end
                ST_PAYLOAD: begin
                    prem = prem - 1;
                    if (prem == 0) st = ST_SPACE;
                    return 0;
                end
                ST_NAN_A: begin
                    if (b != "a") return fail_tok();
                    st = ST_NAN_N;
                    return 0;
                end
                ST_NAN_N: begin
                    if (b != "n") return fail_tok();
                    num = 64'h7FF8_0000_0000_0000;
                    st = ST_SPACE;
                    return 0;
                end
                ST_INF_N: begin
                    if (b != "n") return fail_tok();
                    st = ST_INF_F;
                    return 0;
                end
                ST_INF_F: begin
                    if (b != "f") return fail_tok();
                    num = {neg, 11'h7FF, 52'd0};
                    st = ST_SPACE;
                    return 0;
                end
                ST_HX_LEAD: begin
                    if (b == "0") begin st = ST_HZ_P; return 0; end
                    if (b == "1") begin st = ST_HX_DOT; return 0; end
                    return fail_tok();
                end
                ST_HZ_P: begin
                    if (b != "p") return fail_tok();
                    st = ST_HZ_PLUS;
                    return 0;
                end
                ST_HZ_PLUS: begin
                    if (b != "+") return fail_tok();
                    st = ST_HZ_ZERO;
                    return 0;
                end
                ST_HZ_ZERO: begin
                    if (b != "0") return fail_tok();
                    num = {neg, 63'd0};
                    st = ST_SPACE;
                    return 0;
                end
                ST_HX_DOT: begin
                    if (b == ".") begin st = ST_HX_FRAC; return 0; end
                    if (b == "p") begin st = ST_HX_ESIGN; return 0; end
                    return fail_tok();
                end
                ST_HX_FRAC: begin
                    hv = hex_digit(b);
                    if (hv >= 0 && fcnt < 16) begin
                        frac = frac | (64'(hv) << (60 - 4 * fcnt));
                        fcnt++;
                        return 0;
                    end
                    if (b == "p") begin st = ST_HX_ESIGN; return 0; end
                    return fail_tok();
                end
                ST_HX_ESIGN: begin
                    if (b == "+") eneg = 0;
                    else if (b == "-") eneg = 1;
                    else return fail_tok();
                    st = ST_HX_EFIRST;
                    return 0;
                end
                ST_HX_EFIRST: begin
                    if (b == "0") begin expo = '0; st = ST_HX_ESPACE; return 0; end
                    if (dig) begin expo = 32'(b - "0"); st = ST_HX_EDIG; return 0; end
                    return fail_tok();
                end
                ST_HX_EDIG: begin
                    if (dig) begin
                        if (expo >= 32'd429496729) return fail_tok();
                        expo = expo * 10 + (b - "0");
                        return 0;
                    end
                    if (b == " ") return finish_double();
                    return fail_tok();
                end
                ST_HX_ESPACE: begin
                    if (b == " ") return finish_double();
                    return fail_tok();
                end
                default: begin
                    clear_tok();
                    return 0;
                end
            endcase
        endfunction

        function void note_byte(ttl_in_t d);
            bit was;
            bit n;
            bit r;
            was = disc;
            n = 0;
            if (!was) n = lex_byte(d.in_byte);
            if (d.msg_last) begin
                // truncated item: error token on the last byte
                if (!was && !n && (st != ST_IDLE || neg)) r = emit(ptype, '0, '0, 1);
                clear_tok();
                disc = 0;
                pos = 0;
            end else if (pos < MaxMessage - 1) pos++;
        endfunction

        function void check_token(ttl_out_t got);
            ttl_out_t want;
            if (expected_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected token: type %0d value %h off %0d err %0d",
                        got.tok_type, got.tok_value, got.payload_offset, got.tok_error);
                return;
            end
            want = expected_tokens.pop_front();
            if (got.tok_type !== want.tok_type || got.tok_value !== want.tok_value ||
                got.payload_offset !== want.payload_offset ||
                got.tok_error !== want.tok_error) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("token mismatch: exp %0d/%h/%0d/%0d got %0d/%h/%0d/%0d",
                        want.tok_type, want.tok_value, want.payload_offset, want.tok_error,
                        got.tok_type, got.tok_value, got.payload_offset, got.tok_error);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ttl_in_if  in_ch();
    ttl_out_if out_ch();

    text_token_lexer u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    lexer_scoreboard sb;
    int              send_idle;   // percent of cycles the sender idles
    int              recv_stall;  // percent of cycles the receiver stalls
    int              hold_left;   // long receiver hold-off, counted down below
    logic [7:0]      msg[$];      // message under construction

    initial clk = 0;
    always #5 clk = ~clk;

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else out_ch.ready <= ($urandom_range(99) >= recv_stall);
    end

    // every token transfer is checked against the oldest expectation
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) sb.check_token(out_ch.data);
    end

    // watchdog
    initial begin
        #20ms;
        $display("tb_text_token_lexer: done, errors");
        $finish;
    end

    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
    endtask

    // one byte transfer; valid stays high from one byte to the next unless the sender idles
    task automatic send_byte(logic [7:0] b, logic last);
        ttl_in_t d;
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        d.in_byte = b;
        d.msg_last = last;
        in_ch.valid <= 1'b1;
        in_ch.data <= d;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_byte(d);
    endtask

    task automatic send_msg();
        for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
        msg.delete();
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.expected_tokens.size() != 0) @(posedge clk);
    endtask

    // one random token, mostly well formed
    task automatic add_token();
        string       hexd;
        logic [63:0] v;
        int          k;
        hexd = "0123456789abcdef";
        case ($urandom_range(11))
            0: add_str($urandom_range(1) ? "{ " : "[ ");
            1: add_str($urandom_range(1) ? "} " : "] ");
            2: msg.push_back($urandom_range(1) ? 8'h0A : 8'h00);
            3, 4: begin
                case ($urandom_range(4))
                    0: v = $urandom_range(20);
                    1: v = $urandom;
                    2: v = {$urandom, $urandom};
                    3: v = 64'd2147483645 + $urandom_range(3);
                    default: v = 64'h7FFF_FFFF_FFFF_FFFD + $urandom_range(3);
                endcase
                if ($urandom_range(3) == 0) add_str("-");
                add_str($sformatf("%0d ", v));
            end
            5: add_str($sformatf("%s%0d@ ", $urandom_range(7) == 0 ? "-" : "",
                $urandom_range(1000)));
            6: begin
                k = $urandom_range(6);
                add_str($sformatf("%0d%s", k, $urandom_range(1) ? ":" : ";"));
                repeat (k) msg.push_back(8'($urandom_range(255)));
                add_str(" ");
            end
            7: case ($urandom_range(3))
                0: add_str("nan ");
                1: add_str("inf ");
                2: add_str("-inf ");
                default: add_str($urandom_range(1) ? "0x0p+0 " : "-0x0p+0 ");
            endcase
            8, 9: begin
                if ($urandom_range(2) == 0) add_str("-");
                add_str("0x1");
                k = $urandom_range(16);
                if (k > 0) add_str(".");
                repeat (k) msg.push_back(hexd[$urandom_range(15)]);
                add_str($urandom_range(1) ? "p+" : "p-");
                case ($urandom_range(3))
                    0: add_str("0");
                    1: add_str($sformatf("%0d", $urandom_range(1030)));
                    2: add_str($sformatf("%0d", $urandom_range(2147483650, 2147483640)));
                    default: add_str($sformatf("%0d", $urandom));
                endcase
                add_str(" ");
            end
            10: msg.push_back(8'($urandom_range(255)));
            default: add_str("7 ");
        endcase
    endtask

    task automatic random_bytes(int budget);
        int sent;
        sent = 0;
        while (sent < budget) begin
            repeat ($urandom_range(6, 1)) add_token();
            // sometimes cut the message short to end mid-token
            if ($urandom_range(5) == 0 && msg.size() > 1)
                repeat ($urandom_range(msg.size() - 1, 1)) void'(msg.pop_back());
            sent += msg.size();
            send_msg();
        end
    endtask

    initial begin
        string directed[$];
        sb = new();
        sb.reset_state();
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        send_idle = 0;
        recv_stall = 0;
        hold_left = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed messages: brackets, integer class limits, payload items,
        // special doubles, zero, rounding carry, flush and overflow, errors
        directed = '{"{ [ } ] \n", "0 1 -1 2147483646 2147483647 -2147483647 ",
            "9223372036854775806 9223372036854775807 18446744073709551609 ",
            "-18446744073709551609 ", "184467440737095516150 ", "5@ -5@ ",
            "3:abc 0; -2:xy ", "2147483648: ", "nan inf -inf -nan ", "--1 ",
            "0x0p+0 -0x0p+0 0x1p-0 ", "0x1.fffffffffffffp+0 0x1.0000000000000800p+1 ",
            "0x1p-1022 0x1p-1023 0x1p+1023 0x1p+1024 ",
            "0x1.8p+2147483647 0x1p-2147483648 0x1p+2147483648 0x1p+4294967295 ",
            "12", "-", "q 1 ", "0x1.g ", "{x"};
        foreach (directed[i]) begin
            add_str(directed[i]);
            send_msg();
        end
        msg.push_back(8'h00);
        send_msg();
        msg.push_back(8'hFF);
        send_msg();
        random_bytes(25);
        drain();

        // sender idles
        send_idle = 66;
        random_bytes(25);
        drain();

        // receiver stalls, with a long hold-off so the input backs up
        send_idle = 0;
        recv_stall = 66;
        hold_left = 400;
        random_bytes(25);
        drain();

        // both sides idle
        send_idle = 37;
        recv_stall = 37;
        random_bytes(25);
        drain();

        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_tokens.size() == 0)
            $display("tb_text_token_lexer: done, clean");
        else
            $display("tb_text_token_lexer: done, errors");
        $finish;
    end

endmodule
